// File: hw/rtl/estop_damping_command_scheduler_defines.svh
// Assertion macros for the e-stop damping command scheduler.
// Included by files that carry concurrent assertions; no other dependency.
`ifndef ESTOP_DAMPING_COMMAND_SCHEDULER_DEFINES_SVH
`define ESTOP_DAMPING_COMMAND_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define EDCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EDCS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/edcs_pkg.sv
// Shared types, constants and helper functions of the e-stop damping scheduler.
// No dependencies.
package edcs_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int MAX_MOTORS   = 32;
  localparam int TX_SLOTS     = 3;
  localparam int QUEUE_DEPTH  = 4;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [28:0] FRAME_ID_BASE = 29'h017F_FF00;
  localparam logic [62:0] FRAME_PAYLOAD = 63'h7FFF_7FFF_0000_6666;

  localparam logic [15:0] RST_DEBOUNCE_MS = 16'd50;
  localparam logic [15:0] RST_RESEND_MS   = 16'd10;
  localparam logic [5:0]  RST_MOTOR_COUNT = 6'd12;

  typedef enum logic [2:0] {
    CFG_RELEASE_DEBOUNCE = 3'd0,
    CFG_RESEND_INTERVAL  = 3'd1,
    CFG_MOTOR_COUNT      = 3'd2,
    CFG_PRESSED_LEVEL    = 3'd3,
    CFG_WIRELESS_PRESENT = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_UPDATE,
    FR_REFILL,
    FR_SCAN,
    FR_FLUSH
  } front_state_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_FRAME  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [15:0] release_debounce_ms;
    logic [15:0] resend_interval_ms;
    logic [5:0]  motor_count;
    logic        pressed_level;
    logic        wireless_present;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic       channel;
    logic [5:0] dest_id;
    logic       engaged;
    logic       discard_host;
    logic       last;
  } cmd_t;

  // clamp motor count into 1..MAX_MOTORS
  function automatic logic [5:0] eff_count(logic [5:0] n);
    logic [5:0] r;
    r = n;
    if (n == 6'd0) r = 6'd1;
    if (n > 6'(MAX_MOTORS)) r = 6'(MAX_MOTORS);
    return r;
  endfunction

  function automatic logic [5:0] share_per(logic [5:0] n);
    return 6'(n / NUM_CHANNELS);
  endfunction

  function automatic logic [31:0] low_ones(logic [5:0] k);
    logic [32:0] t;
    t = (33'd1 << k) - 33'd1;
    return t[31:0];
  endfunction

  // channel 0 owns ids 1..per, channel 1 owns per+1..n
  function automatic logic [31:0] share_mask(logic ch, logic [5:0] n);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = low_ones(share_per(n));
    hi = low_ones(n);
    return ch ? (hi & ~lo) : lo;
  endfunction

  function automatic logic [1:0] cap_slots(logic [1:0] s);
    return (s > 2'(TX_SLOTS)) ? 2'(TX_SLOTS) : s;
  endfunction

endpackage

// File: hw/rtl/edcs_queue.sv
// Short command queue between the front sequencer and the output stage.
// Depends on edcs_pkg (cmd_t, QUEUE_DEPTH).
module edcs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  edcs_pkg::cmd_t   push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output edcs_pkg::cmd_t   pop_data
);

  localparam int AW = $clog2(edcs_pkg::QUEUE_DEPTH);

  edcs_pkg::cmd_t mem [edcs_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  assign full     = (count == (AW+1)'(edcs_pkg::QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/edcs_front.sv
// Front sequencer: takes a tick, updates brake state and pending masks, then
// walks motor ids one per cycle unless the queue is full, and queues status
// and frame commands. Depends on edcs_pkg.
module edcs_front (
  input  logic            clk,
  input  logic            rst,
  input  edcs_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            wired_level,
  input  logic            wireless_level,
  input  logic [31:0]     now_ms,
  input  logic [1:0]      channels_enabled,
  input  logic [1:0]      free_slots_ch0,
  input  logic [1:0]      free_slots_ch1,
  input  logic            q_full,
  output logic            q_push,
  output edcs_pkg::cmd_t  q_data
);

  localparam int NC = edcs_pkg::NUM_CHANNELS;

  edcs_pkg::front_state_t state, state_next;

  logic                   engaged;
  logic                   rel_pend;
  logic [31:0]            rel_start;
  logic [NC-1:0][31:0]    next_refill;
  logic [NC-1:0][31:0]    pending;

  logic                   t_wired;
  logic                   t_wireless;
  logic [31:0]            t_now;
  logic [1:0]             t_en;
  logic [1:0]             t_slots0;
  logic [1:0]             t_slots1;

  logic [NC-1:0][1:0]     slots;
  logic [5:0]             scan_id;
  edcs_pkg::cmd_t         held;

  logic                   accept;
  logic                   pressed;
  logic                   eng_upd;
  logic                   release_due;
  logic [5:0]             n_eff;
  logic [4:0]             id_idx;
  logic                   scan_ch;
  logic                   send;
  logic                   advance;

  assign accept  = in_valid && in_ready;
  assign n_eff   = edcs_pkg::eff_count(cfg.motor_count);
  assign pressed = (t_wired == cfg.pressed_level) ||
                   (cfg.wireless_present && (t_wireless == cfg.pressed_level));
  assign release_due = rel_pend &&
                       ((t_now - rel_start) >= {16'd0, cfg.release_debounce_ms});
  assign eng_upd = pressed || (engaged && !release_due);
  assign id_idx  = 5'(scan_id - 6'd1);
  assign scan_ch = (scan_id > edcs_pkg::share_per(n_eff));
  assign send    = t_en[scan_ch] && pending[scan_ch][id_idx] && (slots[scan_ch] != 2'd0);
  assign advance = !(send && q_full);

  always_comb begin
    state_next = state;
    unique case (state)
      edcs_pkg::FR_IDLE:   if (accept) state_next = edcs_pkg::FR_UPDATE;
      edcs_pkg::FR_UPDATE: state_next = edcs_pkg::FR_REFILL;
      edcs_pkg::FR_REFILL: state_next = engaged ? edcs_pkg::FR_SCAN : edcs_pkg::FR_FLUSH;
      edcs_pkg::FR_SCAN:   if (advance && (scan_id == n_eff)) state_next = edcs_pkg::FR_FLUSH;
      edcs_pkg::FR_FLUSH:  if (!q_full) state_next = edcs_pkg::FR_IDLE;
      default:             state_next = edcs_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    q_push   = 1'b0;
    q_data   = held;
    unique case (state)
      edcs_pkg::FR_IDLE: in_ready = 1'b1;
      edcs_pkg::FR_SCAN: q_push = send && !q_full;
      edcs_pkg::FR_FLUSH: begin
        q_push      = !q_full;
        q_data.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edcs_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // brake state and pending masks
  always_ff @(posedge clk) begin
    if (rst) begin
      engaged     <= 1'b0;
      rel_pend    <= 1'b0;
      rel_start   <= '0;
      next_refill <= '0;
      pending     <= '0;
    end else begin
      unique case (state)
        edcs_pkg::FR_UPDATE: begin
          if (pressed) begin
            rel_pend <= 1'b0;
            if (!engaged) begin
              engaged <= 1'b1;
              for (int c = 0; c < NC; c++) begin
                pending[c]     <= edcs_pkg::share_mask(1'(c), n_eff);
                next_refill[c] <= t_now + {16'd0, cfg.resend_interval_ms};
              end
            end
          end else if (engaged) begin
            if (!rel_pend) begin
              rel_pend  <= 1'b1;
              rel_start <= t_now;
            end else if (release_due) begin
              engaged  <= 1'b0;
              rel_pend <= 1'b0;
              pending  <= '0;
            end
          end
        end
        edcs_pkg::FR_REFILL: begin
          if (engaged && (cfg.resend_interval_ms != 16'd0)) begin
            for (int c = 0; c < NC; c++) begin
              if ((pending[c] == '0) && ((t_now - next_refill[c]) < 32'h8000_0000)) begin
                pending[c]     <= edcs_pkg::share_mask(1'(c), n_eff);
                next_refill[c] <= t_now + {16'd0, cfg.resend_interval_ms};
              end
            end
          end
        end
        edcs_pkg::FR_SCAN: begin
          if (send && !q_full) pending[scan_ch][id_idx] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // tick fields, slot budgets, scan counter, held command
  always_ff @(posedge clk) begin
    unique case (state)
      edcs_pkg::FR_IDLE: begin
        if (accept) begin
          t_wired    <= wired_level;
          t_wireless <= wireless_level;
          t_now      <= now_ms;
          t_en       <= channels_enabled;
          t_slots0   <= free_slots_ch0;
          t_slots1   <= free_slots_ch1;
        end
      end
      edcs_pkg::FR_UPDATE: begin
        held.kind         <= edcs_pkg::KIND_STATUS;
        held.channel      <= 1'b0;
        held.dest_id      <= 6'd0;
        held.engaged      <= eng_upd;
        held.discard_host <= eng_upd || engaged;
        held.last         <= 1'b0;
      end
      edcs_pkg::FR_REFILL: begin
        slots[0] <= edcs_pkg::cap_slots(t_slots0);
        slots[1] <= edcs_pkg::cap_slots(t_slots1);
        scan_id  <= 6'd1;
      end
      edcs_pkg::FR_SCAN: begin
        if (send && !q_full) begin
          slots[scan_ch] <= slots[scan_ch] - 2'd1;
          held.kind      <= edcs_pkg::KIND_FRAME;
          held.channel   <= scan_ch;
          held.dest_id   <= scan_id;
        end
        if (advance) scan_id <= scan_id + 6'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/edcs_back.sv
// Back end: pops queued commands and formats them into the registered
// output stream item. Depends on edcs_pkg.
module edcs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  edcs_pkg::cmd_t  q_data,
  output logic            q_pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [103:0]    m_axis_tdata,
  output logic            m_axis_tuser,
  output logic            m_axis_tlast
);

  logic is_frame;

  assign q_pop    = q_valid && (!m_axis_tvalid || m_axis_tready);
  assign is_frame = (q_data.kind == edcs_pkg::KIND_FRAME);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_axis_tuser <= q_data.kind;
      m_axis_tlast <= q_data.last;
      m_axis_tdata <= {3'b000,
                       q_data.discard_host,
                       q_data.engaged,
                       is_frame ? edcs_pkg::FRAME_PAYLOAD : 63'd0,
                       is_frame ? (edcs_pkg::FRAME_ID_BASE | {23'd0, q_data.dest_id}) : 29'd0,
                       q_data.dest_id,
                       q_data.channel};
    end
  end

endmodule

// File: hw/rtl/estop_damping_command_scheduler.sv
// E-stop damping command scheduler, top level. After a tick is accepted the front
// sequencer runs UPDATE, REFILL, SCAN and FLUSH while engaged (SCAN walks the
// N = effective motor count ids, 1..32, one per cycle while the queue is not full)
// and UPDATE, REFILL and FLUSH while released; the next tick is taken in IDLE.
// The status item of a tick reaches the output first; its frames follow.
// Synchronous reset: brake released, masks empty, config registers to their defaults.
`include "estop_damping_command_scheduler_defines.svh"

module estop_damping_command_scheduler (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [15:0]   cfg_wdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // wired_level, wireless_level, now_ms[31:0], channels_enabled[1:0],
  // free_slots_ch0[1:0], free_slots_ch1[1:0]
  input  logic [39:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // channel, dest_id[5:0], ext_can_id[28:0], payload[62:0], engaged,
  // discard_host, 3 pad bits
  output logic [103:0]  m_axis_tdata,
  // kind
  output logic          m_axis_tuser,
  output logic          m_axis_tlast
);

  edcs_pkg::cfg_t  cfg;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  edcs_pkg::cmd_t  q_wdata;
  edcs_pkg::cmd_t  q_rdata;
  logic            in_take;
  logic            out_frame;

  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign out_frame = m_axis_tvalid && (m_axis_tuser == edcs_pkg::KIND_FRAME);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.release_debounce_ms <= edcs_pkg::RST_DEBOUNCE_MS;
      cfg.resend_interval_ms  <= edcs_pkg::RST_RESEND_MS;
      cfg.motor_count         <= edcs_pkg::RST_MOTOR_COUNT;
      cfg.pressed_level       <= 1'b1;
      cfg.wireless_present    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        edcs_pkg::CFG_RELEASE_DEBOUNCE: cfg.release_debounce_ms <= cfg_wdata;
        edcs_pkg::CFG_RESEND_INTERVAL:  cfg.resend_interval_ms  <= cfg_wdata;
        edcs_pkg::CFG_MOTOR_COUNT:      cfg.motor_count         <= cfg_wdata[5:0];
        edcs_pkg::CFG_PRESSED_LEVEL:    cfg.pressed_level       <= cfg_wdata[0];
        edcs_pkg::CFG_WIRELESS_PRESENT: cfg.wireless_present    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  edcs_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .wired_level      (s_axis_tdata[0]),
    .wireless_level   (s_axis_tdata[1]),
    .now_ms           (s_axis_tdata[33:2]),
    .channels_enabled (s_axis_tdata[35:34]),
    .free_slots_ch0   (s_axis_tdata[37:36]),
    .free_slots_ch1   (s_axis_tdata[39:38]),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_wdata)
  );

  edcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  edcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `EDCS_ASSERT_IMP(a_no_push_full, clk, rst, q_push, !q_full, "push into full queue")
  `EDCS_ASSERT_NXT(a_busy_after_tick, clk, rst, in_take, !s_axis_tready, "tick taken while busy")
  `EDCS_ASSERT_IMP(a_frame_engaged, clk, rst, out_frame, m_axis_tdata[99], "frame while released")

endmodule

// File: test/tb_estop_damping_command_scheduler.sv
`timescale 1ns / 100ps
// Testbench for the e-stop damping command scheduler: random and directed ticks,
// with a scoreboard that predicts status and frame items. Depends on edcs_pkg and the RTL.

typedef struct packed {
  edcs_pkg::kind_t kind;
  logic        channel;
  logic [5:0]  dest_id;
  logic [28:0] can_id;
  logic [62:0] payload;
  logic        engaged;
  logic        discard_host;
  logic        last;
} damping_result_t;

class damping_scoreboard;
  logic [15:0] debounce_ms;
  logic [15:0] resend_ms;
  logic [5:0]  motor_count;
  logic        pressed_level;
  logic        wireless_present;
  logic        engaged;
  logic        release_pending;
  logic [31:0] release_start;
  logic [31:0] next_refill[2];
  logic [31:0] pending[2];
  damping_result_t expected_q[$];
  int unsigned errors;

  function new();
    debounce_ms = edcs_pkg::RST_DEBOUNCE_MS;
    resend_ms = edcs_pkg::RST_RESEND_MS;
    motor_count = edcs_pkg::RST_MOTOR_COUNT;
    pressed_level = 1'b1;
    wireless_present = 1'b1;
    engaged = 1'b0;
    release_pending = 1'b0;
    release_start = '0;
    next_refill[0] = '0;
    next_refill[1] = '0;
    pending[0] = '0;
    pending[1] = '0;
    errors = 0;
  endfunction

  function void write_reg(edcs_pkg::cfg_reg_t idx, logic [15:0] v);
    case (idx)
      edcs_pkg::CFG_RELEASE_DEBOUNCE: debounce_ms = v;
      edcs_pkg::CFG_RESEND_INTERVAL:  resend_ms = v;
      edcs_pkg::CFG_MOTOR_COUNT:      motor_count = v[5:0];
      edcs_pkg::CFG_PRESSED_LEVEL:    pressed_level = v[0];
      edcs_pkg::CFG_WIRELESS_PRESENT: wireless_present = v[0];
      default: ;
    endcase
  endfunction

  // ids owned by a channel; the last channel runs to the clamped count
  function void id_span(int c, output int first_id, output int last_id);
    int n;
    n = motor_count;
    if (n < 1) n = 1;
    if (n > edcs_pkg::MAX_MOTORS) n = edcs_pkg::MAX_MOTORS;
    first_id = c * (n / edcs_pkg::NUM_CHANNELS) + 1;
    last_id = (c == edcs_pkg::NUM_CHANNELS - 1) ? n : (c + 1) * (n / edcs_pkg::NUM_CHANNELS);
  endfunction

  function logic [31:0] span_mask(int c);
    int f;
    int l;
    logic [31:0] m;
    m = '0;
    id_span(c, f, l);
    for (int id = f; id <= l; id++) m[id - 1] = 1'b1;
    return m;
  endfunction

  function damping_result_t make_result(edcs_pkg::kind_t k, logic ch, logic [5:0] id,
                                        logic disc);
    damping_result_t r;
    r.kind = k;
    r.channel = ch;
    r.dest_id = id;
    r.can_id = (k == edcs_pkg::KIND_FRAME) ? (edcs_pkg::FRAME_ID_BASE | 29'(id)) : '0;
    r.payload = (k == edcs_pkg::KIND_FRAME) ? edcs_pkg::FRAME_PAYLOAD : '0;
    r.engaged = engaged;
    r.discard_host = disc;
    r.last = 1'b0;
    return r;
  endfunction

  function void note_tick(logic [39:0] d);
    logic wired;
    logic wl;
    logic pressed;
    logic was;
    logic disc;
    logic [31:0] now;
    logic [31:0] sel;
    logic [31:0] gap;
    logic [1:0] en;
    int f;
    int l;
    int slots;
    damping_result_t tick_q[$];
    wired = d[0];
    wl = d[1];
    now = d[33:2];
    en = d[35:34];
    pressed = (wired == pressed_level) || (wireless_present && (wl == pressed_level));
    was = engaged;
    if (pressed) begin
      release_pending = 1'b0;
      if (!engaged) begin
        engaged = 1'b1;
        for (int c = 0; c < edcs_pkg::NUM_CHANNELS; c++) begin
          pending[c] = span_mask(c);
          next_refill[c] = now + 32'(resend_ms);
        end
      end
    end else if (engaged) begin
      if (!release_pending) begin
        release_pending = 1'b1;
        release_start = now;
      end else if (now - release_start >= 32'(debounce_ms)) begin
        engaged = 1'b0;
        release_pending = 1'b0;
        pending[0] = '0;
        pending[1] = '0;
      end
    end
    disc = engaged || was;
    tick_q.push_back(make_result(edcs_pkg::KIND_STATUS, 1'b0, 6'd0, disc));
    if (engaged) begin
      for (int c = 0; c < edcs_pkg::NUM_CHANNELS; c++) begin
        gap = now - next_refill[c];
        if (resend_ms != 0 && pending[c] == 0 && !gap[31]) begin
          pending[c] = span_mask(c);
          next_refill[c] = now + 32'(resend_ms);
        end
      end
      for (int c = 0; c < edcs_pkg::NUM_CHANNELS; c++) begin
        if (en[c]) begin
          slots = (c == 0) ? d[37:36] : d[39:38];
          if (slots > edcs_pkg::TX_SLOTS) slots = edcs_pkg::TX_SLOTS;
          id_span(c, f, l);
          for (int id = f; id <= l; id++) begin
            sel = 32'd1 << (id - 1);
            if ((pending[c] & sel) == 0) continue;
            if (slots == 0) break;
            slots--;
            pending[c] &= ~sel;
            tick_q.push_back(make_result(edcs_pkg::KIND_FRAME, 1'(c), 6'(id), disc));
          end
        end
      end
    end
    tick_q[tick_q.size() - 1].last = 1'b1;
    foreach (tick_q[i]) expected_q.push_back(tick_q[i]);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= 40) $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  task check_result(logic kind, logic [103:0] d, logic last);
    damping_result_t e;
    if (expected_q.size() == 0) begin
      report("unexpected item", d[63:0], '0);
      return;
    end
    e = expected_q.pop_front();
    if (kind !== e.kind) report("kind", 64'(kind), 64'(e.kind));
    if (d[0] !== e.channel) report("channel", 64'(d[0]), 64'(e.channel));
    if (d[6:1] !== e.dest_id) report("dest_id", 64'(d[6:1]), 64'(e.dest_id));
    if (d[35:7] !== e.can_id) report("ext_can_id", 64'(d[35:7]), 64'(e.can_id));
    if (d[98:36] !== e.payload) report("payload", 64'(d[98:36]), 64'(e.payload));
    if (d[99] !== e.engaged) report("engaged", 64'(d[99]), 64'(e.engaged));
    if (d[100] !== e.discard_host) report("discard_host", 64'(d[100]), 64'(e.discard_host));
    if (last !== e.last) report("last", 64'(last), 64'(e.last));
  endtask
endclass

module tb_estop_damping_command_scheduler;
  localparam int STALL_LIMIT = 4000;

  typedef enum int {RX_OPEN, RX_TOGGLE, RX_COIN, RX_CHOKE} rx_mode_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [15:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  damping_scoreboard sb;
  int          burst_left;
  int          run_left;
  logic        want_press;
  logic [31:0] now_cur;
  rx_mode_t    rx_mode;
  int          rx_left;
  int          quiet_cycles;

  estop_damping_command_scheduler i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_tick(input logic w, input logic wl, input logic [31:0] now,
                           input logic [1:0] en, input logic [1:0] s0, input logic [1:0] s1);
    logic [39:0] d;
    d = {s1, s0, en, now, wl, w};
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_tick(d);
    burst_left--;
  endtask

  // hold off the sender until every expected item is back
  task automatic drain(input int quiet);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  task automatic cfg_step(input edcs_pkg::cfg_reg_t idx, input logic [15:0] v);
    cfg_addr <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] db, input logic [15:0] iv,
                               input logic [15:0] cnt, input logic pl, input logic wp);
    drain(40);
    cfg_we <= 1'b1;
    cfg_step(edcs_pkg::CFG_RELEASE_DEBOUNCE, db);
    cfg_step(edcs_pkg::CFG_RESEND_INTERVAL, iv);
    cfg_step(edcs_pkg::CFG_MOTOR_COUNT, cnt);
    cfg_step(edcs_pkg::CFG_PRESSED_LEVEL, 16'(pl));
    cfg_step(edcs_pkg::CFG_WIRELESS_PRESENT, 16'(wp));
    cfg_we <= 1'b0;
  endtask

  // press and release episodes with random content, some noise on the pins
  task automatic random_tick();
    logic w;
    logic wl;
    logic pl;
    logic wp;
    int r;
    pl = sb.pressed_level;
    wp = sb.wireless_present;
    if (run_left == 0) begin
      want_press = 1'($urandom_range(0, 1));
      run_left = $urandom_range(1, 25);
    end
    run_left--;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      w = 1'($urandom_range(0, 1));
      wl = 1'($urandom_range(0, 1));
    end else if (want_press) begin
      if (wp && r < 4) begin
        w = !pl;
        wl = pl;
      end else begin
        w = pl;
        wl = 1'($urandom_range(0, 1));
      end
    end else begin
      w = !pl;
      wl = wp ? !pl : 1'($urandom_range(0, 1));
    end
    r = $urandom_range(0, 31);
    if (r == 0) now_cur = $urandom;
    else if (r == 1) now_cur = 32'hFFFF_FFFF - $urandom_range(0, 20);
    else if (r == 2) now_cur += $urandom_range(0, 70000);
    else now_cur += $urandom_range(0, 4);
    send_tick(w, wl, now_cur,
              ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 2)) : 2'd3,
              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endtask

  task automatic random_phase(input logic [15:0] db, input logic [15:0] iv,
                              input logic [15:0] cnt, input logic pl, input logic wp);
    apply_setting(db, iv, cnt, pl, wp);
    for (int k = 0; k < 63; k++) begin
      if ($urandom_range(0, 39) == 0) drain(0);
      random_tick();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_left = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 80);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_TOGGLE: m_axis_tready <= !m_axis_tready;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    burst_left = 0;
    run_left = 0;
    want_press = 1'b0;
    now_cur = '0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: press on first tick, slots, channels down, refill, debounce
    send_tick(1'b1, 1'b0, 32'd100, 2'd3, 2'd3, 2'd3);
    send_tick(1'b0, 1'b1, 32'd101, 2'd1, 2'd2, 2'd3);
    send_tick(1'b0, 1'b0, 32'd102, 2'd2, 2'd0, 2'd1);
    send_tick(1'b0, 1'b0, 32'd103, 2'd3, 2'd3, 2'd3);
    send_tick(1'b0, 1'b0, 32'd110, 2'd3, 2'd3, 2'd3);
    send_tick(1'b0, 1'b0, 32'd151, 2'd0, 2'd3, 2'd3);
    send_tick(1'b0, 1'b0, 32'd152, 2'd3, 2'd3, 2'd3);
    send_tick(1'b0, 1'b0, 32'd153, 2'd3, 2'd3, 2'd3);
    // time wrap while engaged
    send_tick(1'b1, 1'b1, 32'hFFFF_FFFE, 2'd3, 2'd0, 2'd0);
    send_tick(1'b1, 1'b0, 32'hFFFF_FFFF, 2'd3, 2'd3, 2'd3);
    send_tick(1'b1, 1'b0, 32'd0, 2'd3, 2'd3, 2'd3);
    send_tick(1'b1, 1'b0, 32'd8, 2'd3, 2'd3, 2'd3);
    // count shrunk while engaged with refill off: stale bits stay until release
    apply_setting(16'd0, 16'd0, 16'd4, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 32'd30, 2'd3, 2'd3, 2'd3);
    send_tick(1'b1, 1'b0, 32'd31, 2'd3, 2'd3, 2'd3);
    send_tick(1'b1, 1'b0, 32'd31, 2'd3, 2'd3, 2'd3);
    send_tick(1'b0, 1'b1, 32'd40, 2'd3, 2'd3, 2'd3);
    send_tick(1'b0, 1'b1, 32'd5000, 2'd3, 2'd3, 2'd3);
    // count 0 clamps to one motor, longest debounce and interval
    apply_setting(16'hFFFF, 16'hFFFF, 16'd0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 32'd6000, 2'd3, 2'd3, 2'd3);
    send_tick(1'b0, 1'b0, 32'd71534, 2'd3, 2'd3, 2'd3);
    send_tick(1'b0, 1'b0, 32'd71535, 2'd3, 2'd3, 2'd3);
    now_cur = 32'd71535;

    random_phase(16'd0, 16'd0, 16'd32, 1'b0, 1'b1);
    random_phase(16'd3, 16'd1, 16'd63, 1'b1, 1'b0);
    random_phase(16'd20, 16'd7, 16'd5, 1'b1, 1'b1);
    random_phase(16'hFFFF, 16'hFFFF, 16'd2, 1'b0, 1'b1);
    random_phase(16'd8, 16'd3, 16'd1, 1'b1, 1'b1);
    random_phase(16'd12, 16'd25, 16'd17, 1'b0, 1'b0);
    random_phase(16'd5, 16'd2, 16'd12, 1'b1, 1'b1);

    drain(64);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
